/* rtl/atrp_pkg.sv */
`default_nettype none

package atrp_pkg;

    // Samples are scaled to this width before the rotations
    localparam int SCALED_W = 40;
    // Rotation datapath: scaled sample plus headroom for CORDIC growth
    localparam int DATA_W = SCALED_W + 3;
    // Angle accumulator, Q24 radians
    localparam int ANGLE_W = 28;
    // Result widths, Q13 radians
    localparam int ROLL_W = 16;
    localparam int PITCH_W = 15;
    localparam int M_DATA_W = 32;

    localparam int ANGLE_TABLE_LEN = 24;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [ANGLE_W-1:0] ROLL_LIMIT = 28'sd25736;
    localparam logic signed [ANGLE_W-1:0] PITCH_LIMIT = 28'sd12868;

    // Gain correction: round(0.60725293501 * 2^20)
    localparam int GAIN_W = 20;
    localparam int GAIN_FRAC = 20;
    localparam logic [GAIN_W-1:0] INV_GAIN_Q20 = 20'd636751;
    // Magnitude split into two partial products
    localparam int MAG_W = DATA_W - 1;
    localparam int MAG_LO_W = MAG_W / 2;
    localparam int MAG_HI_W = MAG_W - MAG_LO_W;
    localparam int PROD_LO_W = MAG_LO_W + GAIN_W;
    localparam int PROD_HI_W = MAG_HI_W + GAIN_W;
    localparam int SUM_W = MAG_W + GAIN_W + 1;

    // round(atan(2^-i) * 2^24)
    localparam logic signed [ANGLE_W-1:0] ATAN_Q24 [ANGLE_TABLE_LEN] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069,
        28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
        28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
        28'sd256, 28'sd128, 28'sd64, 28'sd32,
        28'sd16, 28'sd8, 28'sd4, 28'sd2
    };

    // One word in flight through a rotation chain
    typedef struct packed {
        logic                      zero;
        logic signed [DATA_W-1:0]  x;
        logic signed [DATA_W-1:0]  y;
        logic signed [ANGLE_W-1:0] z;
    } lane_t;

    // Q24 to Q13 with round half up, then clamp to +-limit
    function automatic logic signed [ROLL_W-1:0] to_q13(
        input logic signed [ANGLE_W-1:0] z,
        input logic signed [ANGLE_W-1:0] limit
    );
        logic signed [ANGLE_W:0] sum;
        logic signed [ANGLE_W:0] q;
        logic signed [ANGLE_W:0] lim;
        begin
            sum = {z[ANGLE_W-1], z} + (ANGLE_W+1)'(1024);
            q   = sum >>> 11;
            lim = {limit[ANGLE_W-1], limit};
            if (q > lim) begin
                q = lim;
            end else if (q < -lim) begin
                q = -lim;
            end
            return q[ROLL_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/atrp_cordic_cell.sv */
`default_nettype none

module atrp_cordic_cell #(
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  valid_in,
    input  wire atrp_pkg::lane_t       lane_in,
    input  wire logic [SIDE_W-1:0]     side_in,
    output logic                       valid_out,
    output atrp_pkg::lane_t            lane_out,
    output logic [SIDE_W-1:0]          side_out
);

    logic                    valid_reg;
    atrp_pkg::lane_t         lane_reg;
    atrp_pkg::lane_t         lane_next;
    logic [SIDE_W-1:0]       side_reg;
    logic signed [atrp_pkg::DATA_W-1:0] xs;
    logic signed [atrp_pkg::DATA_W-1:0] ys;

    // Rotate toward the x axis by atan(2^-SHIFT)
    always_comb begin
        xs = lane_in.x >>> SHIFT;
        ys = lane_in.y >>> SHIFT;
        lane_next = lane_in;
        if (!lane_in.y[atrp_pkg::DATA_W-1]) begin
            lane_next.x = lane_in.x + ys;
            lane_next.y = lane_in.y - xs;
            lane_next.z = lane_in.z + atrp_pkg::ATAN_Q24[SHIFT];
        end else begin
            lane_next.x = lane_in.x - ys;
            lane_next.y = lane_in.y + xs;
            lane_next.z = lane_in.z - atrp_pkg::ATAN_Q24[SHIFT];
        end
    end

    // Advance valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign lane_out  = lane_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

/* rtl/atrp_cordic.sv */
`default_nettype none

module atrp_cordic #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               en,
    input  wire logic                               valid_in,
    input  wire logic signed [atrp_pkg::DATA_W-1:0] x_in,
    input  wire logic signed [atrp_pkg::DATA_W-1:0] y_in,
    input  wire logic [SIDE_W-1:0]                  side_in,
    output logic                                    valid_out,
    output atrp_pkg::lane_t                         lane_out,
    output logic [SIDE_W-1:0]                       side_out
);

    logic              pre_valid_reg;
    atrp_pkg::lane_t   pre_reg;
    atrp_pkg::lane_t   pre_next;
    logic [SIDE_W-1:0] pre_side_reg;

    logic              valid_chain [STAGES+1];
    atrp_pkg::lane_t   lane_chain  [STAGES+1];
    logic [SIDE_W-1:0] side_chain  [STAGES+1];

    // Flag the zero vector and pre-rotate a left half-plane vector by +-pi/2
    always_comb begin
        pre_next.zero = (x_in == '0) && (y_in == '0);
        pre_next.x    = x_in;
        pre_next.y    = y_in;
        pre_next.z    = '0;
        if (x_in[atrp_pkg::DATA_W-1]) begin
            if (!y_in[atrp_pkg::DATA_W-1]) begin
                pre_next.x = y_in;
                pre_next.y = -x_in;
                pre_next.z = atrp_pkg::HALF_PI_Q24;
            end else begin
                pre_next.x = -y_in;
                pre_next.y = x_in;
                pre_next.z = -atrp_pkg::HALF_PI_Q24;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (en) begin
            pre_valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_reg      <= pre_next;
            pre_side_reg <= side_in;
        end
    end

    assign valid_chain[0] = pre_valid_reg;
    assign lane_chain[0]  = pre_reg;
    assign side_chain[0]  = pre_side_reg;

    // Row of rotation cells, one shift amount each
    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        atrp_cordic_cell #(
            .SHIFT  (i),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (valid_chain[i]),
            .lane_in   (lane_chain[i]),
            .side_in   (side_chain[i]),
            .valid_out (valid_chain[i+1]),
            .lane_out  (lane_chain[i+1]),
            .side_out  (side_chain[i+1])
        );
    end

    assign valid_out = valid_chain[STAGES];
    assign lane_out  = lane_chain[STAGES];
    assign side_out  = side_chain[STAGES];

endmodule

`default_nettype wire

/* rtl/atrp_gain.sv */
`default_nettype none

module atrp_gain (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               en,
    input  wire logic                               valid_in,
    input  wire atrp_pkg::lane_t                    roll_lane,
    input  wire logic signed [atrp_pkg::DATA_W-1:0] neg_ax_in,
    output logic                                    valid_out,
    output logic signed [atrp_pkg::DATA_W-1:0]      mag_out,
    output logic signed [atrp_pkg::DATA_W-1:0]      neg_ax_out,
    output logic signed [atrp_pkg::ROLL_W-1:0]      roll_out
);

    logic [2:0] valid_reg;

    logic [atrp_pkg::MAG_W-1:0]     mag_clamp;
    logic [atrp_pkg::MAG_HI_W-1:0]  hi1_reg;
    logic [atrp_pkg::PROD_LO_W-1:0] plo1_reg;
    logic [atrp_pkg::PROD_LO_W-1:0] plo2_reg;
    logic [atrp_pkg::PROD_HI_W-1:0] phi2_reg;
    logic [atrp_pkg::SUM_W-1:0]     sum_next;
    logic signed [atrp_pkg::DATA_W-1:0] mag_reg;

    logic signed [atrp_pkg::DATA_W-1:0] nax1_reg, nax2_reg, nax3_reg;
    logic signed [atrp_pkg::ROLL_W-1:0] roll_next;
    logic signed [atrp_pkg::ROLL_W-1:0] roll1_reg, roll2_reg, roll3_reg;

    // Clamp negative magnitude, convert roll angle
    always_comb begin
        mag_clamp = roll_lane.x[atrp_pkg::DATA_W-1] ? '0 : roll_lane.x[atrp_pkg::MAG_W-1:0];
        if (roll_lane.zero) begin
            roll_next = '0;
        end else begin
            roll_next = atrp_pkg::to_q13(roll_lane.z, atrp_pkg::ROLL_LIMIT);
        end
    end

    // Combine partial products with round half up, drop fraction bits
    assign sum_next = {phi2_reg, {atrp_pkg::MAG_LO_W{1'b0}}}
                    + atrp_pkg::SUM_W'(plo2_reg)
                    + (atrp_pkg::SUM_W'(1) << (atrp_pkg::GAIN_FRAC - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], valid_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // low partial product
            plo1_reg  <= atrp_pkg::PROD_LO_W'(mag_clamp[atrp_pkg::MAG_LO_W-1:0])
                       * atrp_pkg::PROD_LO_W'(atrp_pkg::INV_GAIN_Q20);
            hi1_reg   <= mag_clamp[atrp_pkg::MAG_W-1:atrp_pkg::MAG_LO_W];
            nax1_reg  <= neg_ax_in;
            roll1_reg <= roll_next;
            // high partial product
            phi2_reg  <= atrp_pkg::PROD_HI_W'(hi1_reg)
                       * atrp_pkg::PROD_HI_W'(atrp_pkg::INV_GAIN_Q20);
            plo2_reg  <= plo1_reg;
            nax2_reg  <= nax1_reg;
            roll2_reg <= roll1_reg;
            // sum and scale
            mag_reg   <= sum_next[atrp_pkg::GAIN_FRAC +: atrp_pkg::DATA_W];
            nax3_reg  <= nax2_reg;
            roll3_reg <= roll2_reg;
        end
    end

    assign valid_out  = valid_reg[2];
    assign mag_out    = mag_reg;
    assign neg_ax_out = nax3_reg;
    assign roll_out   = roll3_reg;

endmodule

`default_nettype wire

/* rtl/accel_tilt_roll_pitch_unit.sv */
// Accelerometer tilt unit: roll = atan2(y, z), pitch = atan2(-x, sqrt(y^2 + z^2)).
// Input channel s_*: one word per sample, x, y, z packed from the low bits up,
// each SAMPLE_WIDTH bits two's complement. Output channel m_*: one word per
// sample, roll (16 bits) and pitch (15 bits), signed radians with 13 fraction bits.
// An all-zero sample returns zero for both angles.
// Datapath: a row of ROTATION_STAGES CORDIC cells for roll, three stages of
// gain correction that yield the y-z magnitude, then a second row of cells for
// pitch. While the skid register is empty, every cell hands its word on each
// cycle, so the unit takes one sample per clock.
// A word passes the roll pre-rotation register and cells, the gain stages,
// the pitch pre-rotation register and cells, then the output register.
// Stall: the output register is backed by a one-word skid register. When the
// receiver holds m_tready low and the skid fills, s_tready drops and the whole
// pipeline holds; no word is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and both output
// registers; the unit holds no other state.
`default_nettype none

module accel_tilt_roll_pitch_unit #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int ROTATION_STAGES = 16,
    localparam int S_DATA_W       = ((3 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // s_tdata: accel_x, accel_y, accel_z (low bits first), zero padded to bytes
    input  wire logic [S_DATA_W-1:0]           s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // m_tdata: roll_angle [15:0], pitch_angle [30:16], zero in bit 31
    output logic [atrp_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready
);

    localparam int GUARD = atrp_pkg::SCALED_W - SAMPLE_WIDTH;

    logic                               en;
    logic signed [atrp_pkg::DATA_W-1:0] ax_ext, ay_ext, az_ext, neg_ax;

    logic                               roll_valid;
    atrp_pkg::lane_t                    roll_lane;
    logic signed [atrp_pkg::DATA_W-1:0] roll_side;

    logic                               gain_valid;
    logic signed [atrp_pkg::DATA_W-1:0] gain_mag;
    logic signed [atrp_pkg::DATA_W-1:0] gain_nax;
    logic signed [atrp_pkg::ROLL_W-1:0] gain_roll;

    logic                               pitch_valid;
    atrp_pkg::lane_t                    pitch_lane;
    logic [atrp_pkg::ROLL_W-1:0]        pitch_side;

    logic signed [atrp_pkg::ROLL_W-1:0] pitch_full;
    logic [atrp_pkg::M_DATA_W-1:0]      word_next;
    logic                               arrive;

    logic                               out_valid_reg, out_valid_next;
    logic [atrp_pkg::M_DATA_W-1:0]      out_data_reg, out_data_next;
    logic                               hold_valid_reg, hold_valid_next;
    logic [atrp_pkg::M_DATA_W-1:0]      hold_data_reg, hold_data_next;

    // Pipeline advances while the skid register is empty
    assign en       = !hold_valid_reg;
    assign s_tready = en;

    // Scale samples by 2^GUARD and extend to the rotation width
    assign ax_ext = atrp_pkg::DATA_W'($signed({s_tdata[SAMPLE_WIDTH-1:0], {GUARD{1'b0}}}));
    assign ay_ext = atrp_pkg::DATA_W'($signed({s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH],
                                               {GUARD{1'b0}}}));
    assign az_ext = atrp_pkg::DATA_W'($signed({s_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH],
                                               {GUARD{1'b0}}}));
    assign neg_ax = -ax_ext;

    // Roll: angle of (z, y), carry -x alongside
    atrp_cordic #(
        .STAGES (ROTATION_STAGES),
        .SIDE_W (atrp_pkg::DATA_W)
    ) u_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (s_tvalid),
        .x_in      (az_ext),
        .y_in      (ay_ext),
        .side_in   (neg_ax),
        .valid_out (roll_valid),
        .lane_out  (roll_lane),
        .side_out  (roll_side)
    );

    // Remove CORDIC gain from the y-z magnitude
    atrp_gain u_gain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .valid_in   (roll_valid),
        .roll_lane  (roll_lane),
        .neg_ax_in  (roll_side),
        .valid_out  (gain_valid),
        .mag_out    (gain_mag),
        .neg_ax_out (gain_nax),
        .roll_out   (gain_roll)
    );

    // Pitch: angle of (magnitude, -x), carry roll result alongside
    atrp_cordic #(
        .STAGES (ROTATION_STAGES),
        .SIDE_W (atrp_pkg::ROLL_W)
    ) u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (gain_valid),
        .x_in      (gain_mag),
        .y_in      (gain_nax),
        .side_in   (gain_roll),
        .valid_out (pitch_valid),
        .lane_out  (pitch_lane),
        .side_out  (pitch_side)
    );

    // Convert pitch and pack the result word
    always_comb begin
        if (pitch_lane.zero) begin
            pitch_full = '0;
        end else begin
            pitch_full = atrp_pkg::to_q13(pitch_lane.z, atrp_pkg::PITCH_LIMIT);
        end
        word_next = {1'b0, pitch_full[atrp_pkg::PITCH_W-1:0], pitch_side};
    end

    assign arrive = pitch_valid && en;

    // Output register with skid: refill from skid first, else take new word
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        if (hold_valid_reg) begin
            if (m_tready) begin
                out_data_next   = hold_data_reg;
                hold_valid_next = 1'b0;
            end
        end else if (arrive) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_next = 1'b1;
                out_data_next  = word_next;
            end else begin
                hold_valid_next = 1'b1;
                hold_data_next  = word_next;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        hold_data_reg <= hold_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/atrp_checker.sv */
`default_nettype none

module atrp_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic [atrp_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // Input backpressure only while a word waits at the output
    a_stall_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no word pending");

    // Input side closes only after an output stall
    a_close_after_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("s_tready fell without a stalled output word");

    // Stalled output word holds
    a_hold_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Pad bit of the result word stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[atrp_pkg::M_DATA_W-1])
        else $error("pad bit set in result word");

endmodule

bind accel_tilt_roll_pitch_unit atrp_checker u_atrp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
